FILE: rtl/leb_pkg.sv
`default_nettype none

package leb_pkg;

    // line geometry
    localparam int LINE_CAPACITY = 64;
    localparam int ADDR_W        = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int CNT_W         = 7;

    // key codes
    localparam logic [7:0] KEY_ENTER     = 8'd13;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_PREFIX    = 8'd224;
    localparam logic [7:0] EXT_RIGHT     = 8'd77;
    localparam logic [7:0] EXT_LEFT      = 8'd75;
    localparam logic [7:0] EXT_DELETE    = 8'd83;

    // decoded operation for the latched key
    typedef enum logic [2:0] {
        OP_RIGHT,
        OP_LEFT,
        OP_DELETE,
        OP_EXT_NOP,
        OP_ENTER,
        OP_PREFIX,
        OP_BKSP,
        OP_INSERT
    } op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CUR,
        IDX_CUR_M1,
        IDX_LEN,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_P1,
        RD_IDX_M1
    } rd_sel_t;

    typedef enum logic {
        WR_RDATA,
        WR_KEY
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_STATUS
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_key;
        logic    clr_ext;
        logic    set_ext;
        logic    set_applied;
        logic    cur_inc;
        logic    cur_dec;
        logic    len_inc;
        logic    len_dec;
        logic    len_clr;
        idx_op_t idx_op;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    emit_status;
        logic    emit_char;
        logic    emit_empty;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic cur_lt_len;
        logic cur_gt_0;
        logic cur_le_len;
        logic len_lt_cap;
        logic len_zero;
        logic idx_p1_lt_len;
        logic idx_gt_cur;
        logic idx_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/line_edit_buffer.sv
`default_nettype none

// Terminal line editor: keeps one line of up to 64 characters and a cursor.
// Input: pulse start with key_byte while busy is low; the beat is taken at
// that edge and busy rises until the key is fully handled.
// Output: every result is a one-cycle beat marked by result_valid; there is
// no back-pressure, so the receiver must take each beat as it comes.
// Editing keys (insert, backspace, arrows, delete, prefix) give one status
// beat; enter gives one beat per character (is_last on the final one), or a
// single line_empty beat, then clears the line.
// Steps per key: latch the key, decode it, do any store shifting, then give
// the beat. Insert moves each char from the cursor to the end up one place,
// one store read and one store write per moved char, then writes the key.
// Delete/backspace move each char after the removed one down the same way.
// Enter reads and then drives each char in turn. A new key may be started
// in the cycle the last beat is shown.
// Reset clears length, cursor and the prefix flag; store contents are left
// as they are and are never read before being written.
module line_edit_buffer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] key_byte,
    output logic            result_valid,
    output logic            result_kind,
    output logic [7:0]      text_char,
    output logic [6:0]      cursor_pos,
    output logic [6:0]      line_len,
    output logic            edit_applied,
    output logic            line_empty,
    output logic            is_last
);
    import leb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: decodes the key and walks the shift / emit loops
    leb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // line store, length/cursor/index counters, result registers
    leb_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_byte     (key_byte),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .text_char    (text_char),
        .cursor_pos   (cursor_pos),
        .line_len     (line_len),
        .edit_applied (edit_applied),
        .line_empty   (line_empty),
        .is_last      (is_last)
    );

endmodule

`default_nettype wire

FILE: rtl/leb_datapath.sv
`default_nettype none

module leb_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          key_byte,
    input  wire leb_pkg::dp_cmd_t    cmd,
    output leb_pkg::dp_status_t      status,
    output logic                     result_valid,
    output logic                     result_kind,
    output logic [7:0]               text_char,
    output logic [6:0]               cursor_pos,
    output logic [6:0]               line_len,
    output logic                     edit_applied,
    output logic                     line_empty,
    output logic                     is_last
);
    import leb_pkg::*;

    logic [7:0]       mem [LINE_CAPACITY];
    logic [7:0]       rdata_reg;
    logic [7:0]       key_reg;
    logic             ext_reg;
    logic             applied_reg;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] rd_idx;
    logic [CNT_W-1:0] idx_p1;

    logic             valid_reg;
    logic             kind_reg;
    logic [7:0]       char_reg;
    logic [CNT_W-1:0] opos_reg;
    logic [CNT_W-1:0] olen_reg;
    logic             oapp_reg;
    logic             oempty_reg;
    logic             olast_reg;

    assign idx_p1 = idx_reg + CNT_W'(1);

    // key decode
    always_comb
    begin
        if (ext_reg)
        begin
            unique case (key_reg)
                EXT_RIGHT:  status.op = OP_RIGHT;
                EXT_LEFT:   status.op = OP_LEFT;
                EXT_DELETE: status.op = OP_DELETE;
                default:    status.op = OP_EXT_NOP;
            endcase
        end
        else
        begin
            unique case (key_reg)
                KEY_ENTER:     status.op = OP_ENTER;
                KEY_PREFIX:    status.op = OP_PREFIX;
                KEY_BACKSPACE: status.op = OP_BKSP;
                default:       status.op = OP_INSERT;
            endcase
        end
        status.cur_lt_len    = cur_reg < len_reg;
        status.cur_gt_0      = cur_reg != '0;
        status.cur_le_len    = cur_reg <= len_reg;
        status.len_lt_cap    = len_reg < CNT_W'(LINE_CAPACITY);
        status.len_zero      = len_reg == '0;
        status.idx_p1_lt_len = idx_p1 < len_reg;
        status.idx_gt_cur    = idx_reg > cur_reg;
        status.idx_last      = idx_p1 == len_reg;
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_clr)
            len_next = '0;
        else if (cmd.len_inc)
            len_next = len_reg + CNT_W'(1);
        else if (cmd.len_dec)
            len_next = len_reg - CNT_W'(1);

        cur_next = cur_reg;
        if (cmd.len_clr)
            cur_next = '0;
        else if (cmd.cur_inc)
            cur_next = cur_reg + CNT_W'(1);
        else if (cmd.cur_dec)
            cur_next = cur_reg - CNT_W'(1);

        case (cmd.idx_op)
            IDX_CUR:    idx_next = cur_reg;
            IDX_CUR_M1: idx_next = cur_reg - CNT_W'(1);
            IDX_LEN:    idx_next = len_reg;
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_p1;
            IDX_DEC:    idx_next = idx_reg - CNT_W'(1);
            default:    idx_next = idx_reg;
        endcase

        case (cmd.rd_sel)
            RD_IDX_P1: rd_idx = idx_p1;
            RD_IDX_M1: rd_idx = idx_reg - CNT_W'(1);
            default:   rd_idx = idx_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            cur_reg   <= '0;
            ext_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            valid_reg <= cmd.emit_status | cmd.emit_char | cmd.emit_empty;
            if (cmd.set_ext)
                ext_reg <= 1'b1;
            else if (cmd.clr_ext)
                ext_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_key)
        begin
            key_reg     <= key_byte;
            applied_reg <= 1'b0;
        end
        else if (cmd.set_applied)
            applied_reg <= 1'b1;

        if (cmd.emit_status)
        begin
            kind_reg   <= 1'b0;
            char_reg   <= 8'd0;
            opos_reg   <= cur_reg;
            olen_reg   <= len_reg;
            oapp_reg   <= applied_reg;
            oempty_reg <= 1'b0;
            olast_reg  <= 1'b1;
        end
        else if (cmd.emit_char)
        begin
            kind_reg   <= 1'b1;
            char_reg   <= rdata_reg;
            opos_reg   <= '0;
            olen_reg   <= '0;
            oapp_reg   <= 1'b1;
            oempty_reg <= 1'b0;
            olast_reg  <= status.idx_last;
        end
        else if (cmd.emit_empty)
        begin
            kind_reg   <= 1'b1;
            char_reg   <= 8'd0;
            opos_reg   <= '0;
            olen_reg   <= '0;
            oapp_reg   <= 1'b0;
            oempty_reg <= 1'b1;
            olast_reg  <= 1'b1;
        end
    end

    // line store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[idx_reg[ADDR_W-1:0]] <= (cmd.wr_sel == WR_KEY) ? key_reg : rdata_reg;
        if (cmd.mem_rd)
            rdata_reg <= mem[rd_idx[ADDR_W-1:0]];
    end

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign text_char    = char_reg;
    assign cursor_pos   = opos_reg;
    assign line_len     = olen_reg;
    assign edit_applied = oapp_reg;
    assign line_empty   = oempty_reg;
    assign is_last      = olast_reg;

endmodule

`default_nettype wire

FILE: rtl/leb_ctrl.sv
`default_nettype none

module leb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire leb_pkg::dp_status_t status,
    output leb_pkg::dp_cmd_t         cmd
);
    import leb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_STATUS;
                unique case (status.op)
                    OP_RIGHT:
                    begin
                        cmd.clr_ext = 1'b1;
                        if (status.cur_lt_len)
                        begin
                            cmd.cur_inc     = 1'b1;
                            cmd.set_applied = 1'b1;
                        end
                    end
                    OP_LEFT:
                    begin
                        cmd.clr_ext = 1'b1;
                        if (status.cur_gt_0)
                        begin
                            cmd.cur_dec     = 1'b1;
                            cmd.set_applied = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        cmd.clr_ext = 1'b1;
                        if (status.cur_lt_len)
                        begin
                            cmd.idx_op      = IDX_CUR;
                            cmd.set_applied = 1'b1;
                            state_next      = ST_DEL_RD;
                        end
                    end
                    OP_EXT_NOP:
                        cmd.clr_ext = 1'b1;
                    OP_PREFIX:
                        cmd.set_ext = 1'b1;
                    OP_BKSP:
                    begin
                        if (status.cur_gt_0 && status.cur_le_len)
                        begin
                            cmd.idx_op      = IDX_CUR_M1;
                            cmd.cur_dec     = 1'b1;
                            cmd.set_applied = 1'b1;
                            state_next      = ST_DEL_RD;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (status.len_lt_cap && status.cur_le_len)
                        begin
                            cmd.idx_op      = IDX_LEN;
                            cmd.set_applied = 1'b1;
                            state_next      = ST_INS_RD;
                        end
                    end
                    OP_ENTER:
                    begin
                        if (status.len_zero)
                        begin
                            cmd.emit_empty = 1'b1;
                            cmd.len_clr    = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = ST_EMIT_RD;
                        end
                    end
                    default: state_next = ST_STATUS;
                endcase
            end
            // close the gap: store[idx] <= store[idx+1]
            ST_DEL_RD:
            begin
                if (status.idx_p1_lt_len)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = ST_STATUS;
                end
            end
            ST_DEL_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_RDATA;
                cmd.idx_op = IDX_INC;
                state_next = ST_DEL_RD;
            end
            // open a gap: store[idx] <= store[idx-1], then key at cursor
            ST_INS_RD:
            begin
                if (status.idx_gt_cur)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wr_sel  = WR_KEY;
                    cmd.len_inc = 1'b1;
                    cmd.cur_inc = 1'b1;
                    state_next  = ST_STATUS;
                end
            end
            ST_INS_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_RDATA;
                cmd.idx_op = IDX_DEC;
                state_next = ST_INS_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                cmd.emit_char = 1'b1;
                cmd.idx_op    = IDX_INC;
                if (status.idx_last)
                begin
                    cmd.len_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                    state_next = ST_EMIT_RD;
            end
            ST_STATUS:
            begin
                cmd.emit_status = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: bench/tb_line_edit_buffer.sv
`timescale 1ns / 1ps

module tb_line_edit_buffer;
    import leb_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_KEYS     = 180;
    // worst run: ~300 keys, each with store shifting plus sender gaps; the
    // watchdog allows ten times the estimated length of such a run
    localparam int WATCHDOG_CYCLES = 400_000;
    localparam int DRAIN_LIMIT     = 20_000;
    // sized for the longest single key, e.g. insert at the head of a 63-char line
    localparam int SETTLE_CYCLES   = 2 * LINE_CAPACITY + 16;
    localparam int MAX_PRINTS      = 40;

    // One result beat, fields in port order.
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [6:0] cur;
        logic [6:0] len;
        logic       applied;
        logic       empty;
        logic       last;
    } line_beat_t;

    // Directed row: the key, and when 'typed' is set the beat it must give.
    typedef struct packed {
        logic [7:0] key;
        logic       typed;
        line_beat_t want;
    } key_row_t;

    // Beats that can be read straight off the key rules.
    localparam line_beat_t NO_BEAT       = '0;
    localparam line_beat_t EMPTY_LINE    = '{1'b1, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1, 1'b1};
    localparam line_beat_t NOTHING_DONE  = '{1'b0, 8'd0, 7'd0, 7'd0, 1'b0, 1'b0, 1'b1};
    localparam line_beat_t FIRST_CHAR_IN = '{1'b0, 8'd0, 7'd1, 7'd1, 1'b1, 1'b0, 1'b1};

    // Opening sequence: every bound case on an empty line, then a short line
    // holding both byte extremes, edited from the middle, a prefix followed by
    // each of enter/prefix/backspace (all swallowed as unknown codes), and enter.
    localparam int DIRECTED_COUNT = 25;
    localparam key_row_t DIRECTED_KEYS [DIRECTED_COUNT] = '{
        '{KEY_ENTER,     1'b1, EMPTY_LINE},     // enter on an empty line
        '{KEY_BACKSPACE, 1'b1, NOTHING_DONE},   // backspace at the start
        '{KEY_PREFIX,    1'b1, NOTHING_DONE},
        '{EXT_LEFT,      1'b1, NOTHING_DONE},   // left at 0
        '{KEY_PREFIX,    1'b1, NOTHING_DONE},
        '{EXT_RIGHT,     1'b1, NOTHING_DONE},   // right at the end
        '{KEY_PREFIX,    1'b1, NOTHING_DONE},
        '{EXT_DELETE,    1'b1, NOTHING_DONE},   // delete at the end
        '{8'd65,         1'b1, FIRST_CHAR_IN},
        '{8'd0,          1'b0, NO_BEAT},        // all-zero byte inserted
        '{8'd255,        1'b0, NO_BEAT},        // all-ones byte inserted
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{EXT_LEFT,      1'b0, NO_BEAT},
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{EXT_LEFT,      1'b0, NO_BEAT},
        '{KEY_BACKSPACE, 1'b0, NO_BEAT},        // backspace mid line
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{EXT_DELETE,    1'b0, NO_BEAT},        // delete at the cursor
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{KEY_ENTER,     1'b0, NO_BEAT},        // enter as extended code
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{KEY_PREFIX,    1'b0, NO_BEAT},        // prefix as extended code
        '{KEY_PREFIX,    1'b0, NO_BEAT},
        '{KEY_BACKSPACE, 1'b0, NO_BEAT},        // backspace as extended code
        '{KEY_ENTER,     1'b0, NO_BEAT}
    };

    // Sender idle percentage per random phase. The receiver cannot stall, so
    // only the sender side idles.
    localparam int IDLE_PCT [3] = '{0, 63, 38};

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] key_byte;
    logic       result_valid;
    logic       result_kind;
    logic [7:0] text_char;
    logic [6:0] cursor_pos;
    logic [6:0] line_len;
    logic       edit_applied;
    logic       line_empty;
    logic       is_last;

    line_edit_buffer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .key_byte     (key_byte),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .text_char    (text_char),
        .cursor_pos   (cursor_pos),
        .line_len     (line_len),
        .edit_applied (edit_applied),
        .line_empty   (line_empty),
        .is_last      (is_last)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the editor: line contents, length, cursor, prefix flag.
    // ------------------------------------------------------------------
    logic [7:0] line_shadow [LINE_CAPACITY];
    int         len_shadow = 0;
    int         cur_shadow = 0;
    logic       ext_armed  = 1'b0;

    // Beats owed by the block, oldest first.
    line_beat_t pending_beats [$];

    int idle_pct      = 0;
    int keys_sent     = 0;
    int beats_checked = 0;
    int mismatches    = 0;
    int full_drops    = 0;
    int lines_emitted = 0;
    int longest_line  = 0;
    int drains_done   = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h",
                                      beats_checked, name, got, want));
    endtask

    // Take out the char at pos; the tail moves down one place.
    task automatic drop_char(input int pos);
        int i;
        for (i = pos; i + 1 < len_shadow; i++)
            line_shadow[i] = line_shadow[i + 1];
        len_shadow--;
    endtask

    // Advance the shadow by one key and queue the beats it owes.
    task automatic apply_key(input logic [7:0] k);
        int   i;
        logic hit;
        hit = 1'b0;
        if (ext_armed)
        begin
            // any byte after the prefix is the extended code
            ext_armed = 1'b0;
            if (k == EXT_RIGHT)
            begin
                if (cur_shadow < len_shadow)
                begin
                    cur_shadow++;
                    hit = 1'b1;
                end
            end
            else if (k == EXT_LEFT)
            begin
                if (cur_shadow > 0)
                begin
                    cur_shadow--;
                    hit = 1'b1;
                end
            end
            else if (k == EXT_DELETE)
            begin
                if (cur_shadow < len_shadow)
                begin
                    drop_char(cur_shadow);
                    hit = 1'b1;
                end
            end
        end
        else if (k == KEY_ENTER)
        begin
            // no status beat: just the line, or the empty marker
            if (len_shadow == 0)
                pending_beats.push_back('{1'b1, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1, 1'b1});
            for (i = 0; i < len_shadow; i++)
                pending_beats.push_back('{1'b1, line_shadow[i], 7'd0, 7'd0, 1'b1, 1'b0,
                                          (i == len_shadow - 1)});
            lines_emitted++;
            if (len_shadow > longest_line)
                longest_line = len_shadow;
            len_shadow = 0;
            cur_shadow = 0;
            return;
        end
        else if (k == KEY_PREFIX)
        begin
            ext_armed = 1'b1;
        end
        else if (k == KEY_BACKSPACE)
        begin
            if (cur_shadow > 0)
            begin
                drop_char(cur_shadow - 1);
                cur_shadow--;
                hit = 1'b1;
            end
        end
        else if (len_shadow < LINE_CAPACITY)
        begin
            for (i = len_shadow; i > cur_shadow; i--)
                line_shadow[i] = line_shadow[i - 1];
            line_shadow[cur_shadow] = k;
            len_shadow++;
            cur_shadow++;
            hit = 1'b1;
        end
        else
        begin
            full_drops++;
        end
        pending_beats.push_back('{1'b0, 8'd0, 7'(cur_shadow), 7'(len_shadow), hit,
                                  1'b0, 1'b1});
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobed beat is matched against the oldest
    // owed beat, field by field. Sampled at the rising edge, so the values
    // seen are the ones the block showed during the cycle just ended.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        line_beat_t want;
        if (rst_n === 1'b1)
        begin
            if ($isunknown(result_valid))
            begin
                report_mismatch("result_valid is unknown");
            end
            else if (result_valid)
            begin
                if (pending_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat kind=%0b char=0x%0h",
                                              result_kind, text_char));
                end
                else
                begin
                    want = pending_beats.pop_front();
                    check_field("result_kind",  8'(result_kind),  8'(want.kind));
                    check_field("text_char",    text_char,        want.ch);
                    check_field("cursor_pos",   8'(cursor_pos),   8'(want.cur));
                    check_field("line_len",     8'(line_len),     8'(want.len));
                    check_field("edit_applied", 8'(edit_applied), 8'(want.applied));
                    check_field("line_empty",   8'(line_empty),   8'(want.empty));
                    check_field("is_last",      8'(is_last),      8'(want.last));
                    beats_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Key driver. Entered just after a falling edge; inputs change only on
    // falling edges. A key is taken at the first rising edge with busy low.
    // start stays high across back-to-back keys, so it is never dropped and
    // raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_key(input logic [7:0] k, input logic typed = 1'b0,
                            input line_beat_t want = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start    = 1'b1;
        key_byte = k;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_key(k);
        // directed rows with a typed-in beat replace the predicted one
        if (typed)
            pending_beats[$] = want;
        keys_sent++;
        @(negedge clk);
    endtask

    // Printable-or-not payload byte that is an ordinary insert.
    function automatic logic [7:0] random_glyph();
        logic [7:0] k;
        do
            k = 8'($urandom_range(255));
        while (k == KEY_ENTER || k == KEY_BACKSPACE || k == KEY_PREFIX);
        return k;
    endfunction

    // One typed line ending in enter. Normal lines are short and edited
    // heavily; a full line overfills the store with the cursor wandering
    // left, so inserts shift long tails and the extra chars are dropped.
    task automatic type_session(input bit full_line);
        int goal;
        int typed_chars;
        int pick;
        goal        = full_line ? LINE_CAPACITY + $urandom_range(1, 4) : $urandom_range(0, 12);
        typed_chars = 0;
        while (typed_chars < goal)
        begin
            pick = $urandom_range(99);
            if (pick < (full_line ? 85 : 55))
            begin
                send_key(random_glyph());
                typed_chars++;
            end
            else if (full_line || pick < 65)
            begin
                send_key(KEY_PREFIX);
                send_key(EXT_LEFT);
            end
            else if (pick < 73)
            begin
                send_key(KEY_PREFIX);
                send_key(EXT_RIGHT);
            end
            else if (pick < 81)
            begin
                send_key(KEY_PREFIX);
                send_key(EXT_DELETE);
            end
            else if (pick < 89)
            begin
                send_key(KEY_BACKSPACE);
            end
            else if (pick < 94)
            begin
                // prefix with an arbitrary code, mostly ignored
                send_key(KEY_PREFIX);
                send_key(8'($urandom_range(255)));
            end
            else
            begin
                // raw noise byte; may end the line early or arm a prefix
                send_key(8'($urandom_range(255)));
            end
        end
        send_key(KEY_ENTER);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int row;
        int phase;
        int full_sessions;
        int spins;
        bit want_full;
        rst_n    = 1'b0;
        start    = 1'b0;
        key_byte = 8'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, back to back
        for (row = 0; row < DIRECTED_COUNT; row++)
            send_key(DIRECTED_KEYS[row].key, DIRECTED_KEYS[row].typed,
                     DIRECTED_KEYS[row].want);

        // random part in three idling phases
        phase         = 0;
        full_sessions = 0;
        while (keys_sent - DIRECTED_COUNT < RANDOM_KEYS)
        begin
            // hold off until the block has given every owed beat: always at a
            // phase change, now and then otherwise
            if ((keys_sent - DIRECTED_COUNT) * 3 / RANDOM_KEYS != phase
                || $urandom_range(4) == 0)
            begin
                start = 1'b0;
                while (pending_beats.size() != 0)
                    @(negedge clk);
                drains_done++;
            end
            phase    = (keys_sent - DIRECTED_COUNT) * 3 / RANDOM_KEYS;
            idle_pct = IDLE_PCT[phase];
            want_full = (phase == 1 && full_sessions == 0)
                        || (full_sessions < 3 && $urandom_range(24) == 0);
            if (want_full)
                full_sessions++;
            type_session(want_full);
        end

        // wind down: wait for the owed beats, then for any stray ones
        start = 1'b0;
        spins = 0;
        while (pending_beats.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_beats.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));

        $display("Run: %0d keys (%0d directed), %0d beats checked, %0d lines emitted,",
                 keys_sent, DIRECTED_COUNT, beats_checked, lines_emitted);
        $display("     longest line %0d chars, %0d inserts dropped on a full line, %0d drains",
                 longest_line, full_drops, drains_done);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("Watchdog expired with %0d beats owed", pending_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
